// ----- src/bsa_pkg.sv -----
// Shared types and constants for the bitmap slot allocator.
// Field widths, status and register codes, controller states and the
// command/status bundles between controller and datapath. No dependencies.
package bsa_pkg;

  localparam int CNT_W   = 11;
  localparam int IDX_W   = 10;
  localparam int OFF_W   = 21;
  localparam int OBJ_W   = 17;
  localparam int CFG_I_W = 2;
  localparam int IN_W    = 24;
  localparam int OUT_W   = 48;

  localparam int OBJ_MAX = 65536;

  localparam int DEF_SLOTS       = 1024;
  localparam int DEF_WORD_BITS   = 32;
  localparam int DEF_CHUNK_BYTES = 2097152;

  localparam logic [CNT_W-1:0] RST_SLOT_COUNT   = 11'd1024;
  localparam logic [OBJ_W-1:0] RST_OBJECT_BYTES = 17'd64;
  localparam logic [OFF_W-1:0] RST_DATA_OFFSET  = 21'd4096;

  localparam logic [CFG_I_W-1:0] REG_SLOT_COUNT   = 2'd0;
  localparam logic [CFG_I_W-1:0] REG_OBJECT_BYTES = 2'd1;
  localparam logic [CFG_I_W-1:0] REG_DATA_OFFSET  = 2'd2;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_BAD_ADDR  = 2'd2,
    STAT_NOT_ALLOC = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALLOC_INIT,
    S_SCAN,
    S_FREE_RANGE,
    S_DIV,
    S_FREE_CHK,
    S_FREE_BIT,
    S_MUL,
    S_ADD,
    S_OUT
  } state_t;

  typedef struct packed {
    logic    load;
    logic    scan_init;
    logic    scan_step;
    logic    alloc_commit;
    logic    div_start;
    logic    free_rd;
    logic    free_commit;
    logic    mul;
    logic    add;
    logic    set_err;
    status_t err_code;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic fc_zero;
    logic scan_hit;
    logic scan_miss;
    logic range_bad;
    logic div_busy;
    logic quot_bad;
    logic bit_clear;
    logic out_free;
  } stat_t;

endpackage

// ----- src/bsa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module bsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/bsa_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on nothing.
module bsa_div #(
  parameter int NUM_W = 21,
  parameter int DEN_W = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quot,
  output logic [DEN_W-1:0] rem
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy_r;
  logic [CW-1:0]    cnt_r;
  logic [NUM_W-1:0] quot_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   trial;
  logic             qbit;

  always_comb begin
    trial = {rem_r, quot_r[NUM_W-1]};
    qbit  = (trial >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(NUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= num;
      rem_r  <= '0;
      den_r  <= den;
    end else if (busy_r) begin
      quot_r <= {quot_r[NUM_W-2:0], qbit};
      rem_r  <= qbit ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
    end
  end

  assign busy = busy_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

// ----- src/bsa_dp.sv -----
// Datapath: config registers, occupancy bitmap RAM with word valid bits,
// scan pipeline, divider, offset multiply-add and output register.
// Depends on bsa_pkg, bsa_ram and bsa_div.
module bsa_dp import bsa_pkg::*; #(
  parameter int SLOTS       = DEF_SLOTS,
  parameter int WORD_BITS   = DEF_WORD_BITS,
  parameter int CHUNK_BYTES = DEF_CHUNK_BYTES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output stat_t              st,
  input  logic [IN_W-1:0]    in_tdata,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CFG_I_W-1:0] cfg_index,
  input  logic [OFF_W-1:0]   cfg_data,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [OUT_W-1:0]   out_tdata
);

  localparam int WORDS  = (SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int WI_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int BI_W   = $clog2(WORD_BITS);
  localparam int SI_W   = $clog2(SLOTS);
  localparam int PROD_W = OBJ_W + SI_W;
  localparam logic [WORD_BITS-1:0] ONES = '1;
  localparam logic [WORD_BITS-1:0] ONE  = WORD_BITS'(1);

  function automatic logic [CNT_W-1:0] eff_slots(input logic [CNT_W-1:0] sc);
    if (32'(sc) > SLOTS) begin
      return CNT_W'(SLOTS);
    end
    return sc;
  endfunction

  logic [CNT_W-1:0]     slot_count_r;
  logic [OBJ_W-1:0]     obj_r;
  logic [OFF_W-1:0]     doff_r;
  logic [CNT_W-1:0]     hint_r;
  logic [CNT_W-1:0]     fc_r;
  logic [WORDS-1:0]     valid_r;
  logic                 rdv_r;
  logic [OFF_W-1:0]     addr_r;

  logic                 iss_act_r;
  logic [WI_W-1:0]      iss_w_r;
  logic                 iss_pass_r;
  logic                 chk_v_r;
  logic [WI_W-1:0]      chk_w_r;
  logic                 chk_pass_r;

  logic [SI_W-1:0]      fidx_r;
  logic [WI_W-1:0]      fw_r;

  status_t              res_status_r;
  logic [SI_W-1:0]      res_idx_r;
  logic [OFF_W-1:0]     res_off_r;
  logic                 res_empty_r;
  logic [PROD_W-1:0]    prod_r;

  logic                 out_valid_r;
  logic [OUT_W-1:0]     out_data_r;

  logic [CNT_W-1:0]     n;
  logic [CNT_W-1:0]     n_m1;
  logic [OBJ_W-1:0]     ob_eff;
  logic [WI_W-1:0]      last_w;
  logic [BI_W-1:0]      last_b;
  logic [WI_W-1:0]      hint_w;
  logic [BI_W-1:0]      hint_b;
  logic [WORD_BITS-1:0] ram_q;
  logic [WORD_BITS-1:0] rd_word;
  logic [WORD_BITS-1:0] lo_mask;
  logic [WORD_BITS-1:0] hi_mask;
  logic [WORD_BITS-1:0] free_bits;
  logic [BI_W-1:0]      pos;
  logic                 hit;
  logic [SI_W-1:0]      alloc_idx;
  logic [BI_W-1:0]      fbit;

  logic                 ram_we;
  logic [WI_W-1:0]      ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [WI_W-1:0]      ram_raddr;

  logic [OFF_W-1:0]     div_quot;
  logic [OBJ_W-1:0]     div_rem;
  logic                 div_busy;
  logic [OFF_W-1:0]     div_num;
  logic [WI_W-1:0]      q_w;
  logic                 cfg_acc;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid;

  always_comb begin
    n    = eff_slots(slot_count_r);
    n_m1 = n - 1'b1;
    if (obj_r == '0) begin
      ob_eff = OBJ_W'(1);
    end else if (32'(obj_r) > OBJ_MAX) begin
      ob_eff = OBJ_W'(OBJ_MAX);
    end else begin
      ob_eff = obj_r;
    end
    last_w  = WI_W'(n_m1 / WORD_BITS);
    last_b  = BI_W'(n_m1 % WORD_BITS);
    hint_w  = WI_W'(hint_r / WORD_BITS);
    hint_b  = BI_W'(hint_r % WORD_BITS);
    rd_word = rdv_r ? ram_q : '0;
    lo_mask = (!chk_pass_r && (chk_w_r == hint_w)) ? ~(ONES << hint_b) : '0;
    hi_mask = (chk_w_r == last_w) ? ((ONES << last_b) << 1) : '0;
    free_bits = ~(rd_word | lo_mask | hi_mask);
    pos = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        pos = BI_W'(b);
      end
    end
    hit       = |free_bits;
    alloc_idx = SI_W'(32'(chk_w_r) * WORD_BITS + 32'(pos));
    fbit      = BI_W'(fidx_r % WORD_BITS);
    div_num   = addr_r - doff_r;
    q_w       = WI_W'(div_quot / WORD_BITS);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = chk_w_r;
    ram_wdata = rd_word | (ONE << pos);
    if (cmd.free_commit) begin
      ram_we    = 1'b1;
      ram_waddr = fw_r;
      ram_wdata = rd_word & ~(ONE << fbit);
    end else if (cmd.alloc_commit) begin
      ram_we = 1'b1;
    end
    ram_re    = (cmd.scan_step && iss_act_r) || cmd.free_rd;
    ram_raddr = cmd.free_rd ? q_w : iss_w_r;
  end

  always_comb begin
    st.fc_zero   = (fc_r == '0);
    st.scan_hit  = chk_v_r && hit;
    st.scan_miss = chk_v_r && !hit && chk_pass_r && (chk_w_r == last_w);
    st.range_bad = (addr_r < doff_r) || (32'(addr_r) >= CHUNK_BYTES);
    st.div_busy  = div_busy;
    st.quot_bad  = (div_rem != '0) || (div_quot >= OFF_W'(n));
    st.bit_clear = !rd_word[fbit];
    st.out_free  = !out_valid_r || out_tready;
  end

  bsa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  bsa_div #(
    .NUM_W (OFF_W),
    .DEN_W (OBJ_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (ob_eff),
    .busy  (div_busy),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  // pool state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r <= RST_SLOT_COUNT;
      obj_r        <= RST_OBJECT_BYTES;
      doff_r       <= RST_DATA_OFFSET;
      hint_r       <= '0;
      fc_r         <= eff_slots(RST_SLOT_COUNT);
      valid_r      <= '0;
      rdv_r        <= 1'b0;
    end else begin
      if (ram_re) begin
        rdv_r <= valid_r[ram_raddr];
      end
      if (cfg_acc && (cfg_index == REG_SLOT_COUNT)) begin
        valid_r <= '0;
      end else if (ram_we) begin
        valid_r[ram_waddr] <= 1'b1;
      end
      if (cfg_acc) begin
        case (cfg_index)
          REG_SLOT_COUNT: begin
            slot_count_r <= cfg_data[CNT_W-1:0];
            hint_r       <= '0;
            fc_r         <= eff_slots(cfg_data[CNT_W-1:0]);
          end
          REG_OBJECT_BYTES: obj_r  <= cfg_data[OBJ_W-1:0];
          REG_DATA_OFFSET:  doff_r <= cfg_data;
          default: ;
        endcase
      end else if (cmd.alloc_commit) begin
        fc_r   <= fc_r - 1'b1;
        hint_r <= CNT_W'(alloc_idx) + 1'b1;
      end else if (cmd.free_commit) begin
        fc_r <= fc_r + 1'b1;
        if (fc_r == '0) begin
          hint_r <= CNT_W'(fidx_r);
        end
      end
    end
  end

  // scan pipeline: issue stage and check stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_act_r <= 1'b0;
      chk_v_r   <= 1'b0;
    end else if (cmd.scan_init) begin
      iss_act_r <= 1'b1;
      chk_v_r   <= 1'b0;
    end else if (cmd.scan_step) begin
      chk_v_r <= iss_act_r && !st.scan_hit;
      if (iss_act_r && (iss_w_r == last_w) && iss_pass_r) begin
        iss_act_r <= 1'b0;
      end
    end else begin
      iss_act_r <= 1'b0;
      chk_v_r   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      if (hint_r >= n) begin
        iss_w_r    <= '0;
        iss_pass_r <= 1'b1;
      end else begin
        iss_w_r    <= hint_w;
        iss_pass_r <= 1'b0;
      end
    end else if (cmd.scan_step) begin
      chk_w_r    <= iss_w_r;
      chk_pass_r <= iss_pass_r;
      if (iss_w_r == last_w) begin
        iss_w_r    <= '0;
        iss_pass_r <= 1'b1;
      end else begin
        iss_w_r <= iss_w_r + 1'b1;
      end
    end
  end

  // transaction result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_r       <= in_tdata[OFF_W-1:0];
      res_status_r <= STAT_OK;
      res_idx_r    <= '0;
      res_off_r    <= '0;
      res_empty_r  <= 1'b0;
    end
    if (cmd.set_err) begin
      res_status_r <= cmd.err_code;
    end
    if (cmd.alloc_commit) begin
      res_idx_r <= alloc_idx;
    end
    if (cmd.free_rd) begin
      fidx_r <= SI_W'(div_quot);
      fw_r   <= q_w;
    end
    if (cmd.free_commit) begin
      res_idx_r   <= fidx_r;
      res_empty_r <= (CNT_W'(fc_r + 1'b1) == n);
    end
    if (cmd.mul) begin
      prod_r <= ob_eff * res_idx_r;
    end
    if (cmd.add) begin
      res_off_r <= doff_r + prod_r[OFF_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {2'b00, (fc_r == '0), res_empty_r, fc_r, res_off_r,
                     IDX_W'(res_idx_r), res_status_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- src/bsa_ctrl.sv -----
// Controller state machine sequencing allocate and free transactions.
// Depends on bsa_pkg.
module bsa_ctrl import bsa_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  input  logic  in_tuser,
  output logic  in_tready,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = in_tuser ? S_FREE_RANGE : S_ALLOC_INIT;
        end
      end
      S_ALLOC_INIT: begin
        if (st.fc_zero) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = STAT_FULL;
          state_nxt    = S_OUT;
        end else begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_hit) begin
          cmd.alloc_commit = 1'b1;
          state_nxt        = S_MUL;
        end else if (st.scan_miss) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = STAT_FULL;
          state_nxt    = S_OUT;
        end
      end
      S_FREE_RANGE: begin
        if (st.range_bad) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = STAT_BAD_ADDR;
          state_nxt    = S_OUT;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (!st.div_busy) begin
          state_nxt = S_FREE_CHK;
        end
      end
      S_FREE_CHK: begin
        if (st.quot_bad) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = STAT_BAD_ADDR;
          state_nxt    = S_OUT;
        end else begin
          cmd.free_rd = 1'b1;
          state_nxt   = S_FREE_BIT;
        end
      end
      S_FREE_BIT: begin
        if (st.bit_clear) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = STAT_NOT_ALLOC;
          state_nxt    = S_OUT;
        end else begin
          cmd.free_commit = 1'b1;
          state_nxt       = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ----- src/bitmap_slot_allocator_core.sv -----
// Bitmap slot allocator: one chunk of equal-sized slots tracked by an
// occupancy bitmap held in a RAM of WORD_BITS-wide words, a free count and a
// next-fit hint. One transaction is in progress at a time. In an allocate the
// scan reads one bitmap word a cycle from the hint, wrapping to word 0, so at
// most twice the number of words are read. A free is paced by the 21-step
// serial divider that turns the byte offset into a slot index. A new
// transaction is taken while the previous result waits in the output
// register. The bitmap needs no clearing pass: per-word valid bits are
// cleared at reset and on a slot_count write. Config writes are accepted in
// every cycle and must only be issued while the block is idle.
module bitmap_slot_allocator_core import bsa_pkg::*; #(
  parameter int SLOTS       = DEF_SLOTS,
  parameter int WORD_BITS   = DEF_WORD_BITS,
  parameter int CHUNK_BYTES = DEF_CHUNK_BYTES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [IN_W-1:0]    in_tdata,   // free_offset[20:0], zero pad
  input  logic               in_tuser,   // kind
  output logic               out_tvalid,
  input  logic               out_tready,
  // status[1:0], slot_index[11:2], slot_offset[32:12], free_slots[43:33],
  // chunk_empty[44], chunk_full[45], zero pad
  output logic [OUT_W-1:0]   out_tdata,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CFG_I_W-1:0] cfg_index,
  input  logic [OFF_W-1:0]   cfg_data
);

  cmd_t  cmd;
  stat_t st;

  bsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  bsa_dp #(
    .SLOTS       (SLOTS),
    .WORD_BITS   (WORD_BITS),
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
